@@ rtl/core/tkus_pkg.sv @@
// ---------------------------------------------------------------------------
// tkus_pkg: shared types and constants for the top-K score table
// Request and response payloads, stage handover type, status and opcode codes.
// ---------------------------------------------------------------------------
package tkus_pkg;

  localparam int TABLE_SIZE_DEF = 16;
  localparam int VAL_W          = 8;

  localparam logic [VAL_W-1:0] MAX_VAL   = 8'd255;
  // points / 10 == (points * 52429) >> 19 for every 16-bit value
  localparam logic [16:0]      DIV_RECIP = 17'd52429;
  localparam int               DIV_SHIFT = 19;

  localparam logic OP_SUBMIT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_TOO_LOW   = 3'd2;
  localparam logic [2:0] ST_ZERO      = 3'd3;
  localparam logic [2:0] ST_READ_DONE = 3'd4;

  typedef struct packed {
    logic        opcode;
    logic [15:0] score_points;
    logic [3:0]  read_slot;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] entry_points;
    logic        entry_valid;
    logic [4:0]  entry_total;
  } rsp_t;

  // scaled request handed from the front stage to the cell row
  typedef struct packed {
    logic             op;
    logic [VAL_W-1:0] v;
    logic [3:0]       slot;
  } prep_t;

endpackage

@@ rtl/core/top_k_unique_score_table.sv @@
// ---------------------------------------------------------------------------
// top_k_unique_score_table: sorted table of the best distinct scores
//
// Request channel (req_valid, req_stall, req_data): a submit request offers a
// score in points, a read request asks for the entry at one rank. Response
// channel (rsp_valid, rsp_stall, rsp_data): exactly one response per request,
// in request order, carrying status, entry value in points and entry count.
// A request moves on a rising edge with valid high and stall low.
// The front stage scales the score (one multiply) and registers the request.
// As the request leaves it, the row of cells is updated and the response
// registered; each cell compares against the new value and keeps its entry,
// takes the new value or its left neighbour's entry. One request per cycle is
// sustained while the receiver keeps up. When rsp_stall is high the response
// register holds, the front stage fills, and then req_stall rises until the
// response is taken.
// Reset empties the table (all cells invalid, count zero).
// ---------------------------------------------------------------------------
module top_k_unique_score_table #(
  parameter int TABLE_SIZE = tkus_pkg::TABLE_SIZE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  tkus_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output tkus_pkg::rsp_t rsp_data
);
  import tkus_pkg::*;

  localparam int CW = $clog2(TABLE_SIZE + 1);

  logic             a_vld;
  prep_t            a_data;
  logic             accept;
  logic             advance;

  logic [VAL_W-1:0] cell_val [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] cell_vld;
  logic [TABLE_SIZE-1:0] keep_vec;
  logic [TABLE_SIZE-1:0] match_vec;

  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic             full;
  logic             dup;
  logic             zero;
  logic             too_low;
  logic             insert;
  logic             upd;

  logic [VAL_W-1:0] rd_val;
  logic             rd_vld;
  logic [CW+4:0]    total_ext;
  rsp_t             rsp_data_next;
  logic             rsp_valid_next;

  assign advance   = a_vld && (!rsp_valid || !rsp_stall);
  assign req_stall = a_vld && !advance;
  assign accept    = req_valid && !req_stall;

  tkus_prep u_prep (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .advance (advance),
    .req     (req_data),
    .a_vld   (a_vld),
    .a_data  (a_data)
  );

  for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_cell
    if (i == 0) begin : g_head
      tkus_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .upd       (upd),
        .v         (a_data.v),
        .prev_keep (1'b1),
        .prev_val  ('0),
        .prev_vld  (1'b0),
        .val       (cell_val[i]),
        .vld       (cell_vld[i]),
        .keep      (keep_vec[i]),
        .match     (match_vec[i])
      );
    end else begin : g_body
      tkus_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .upd       (upd),
        .v         (a_data.v),
        .prev_keep (keep_vec[i-1]),
        .prev_val  (cell_val[i-1]),
        .prev_vld  (cell_vld[i-1]),
        .val       (cell_val[i]),
        .vld       (cell_vld[i]),
        .keep      (keep_vec[i]),
        .match     (match_vec[i])
      );
    end
  end

  assign full    = (count == CW'(TABLE_SIZE));
  assign dup     = |match_vec;
  assign zero    = (a_data.v == '0);
  assign too_low = full && keep_vec[TABLE_SIZE-1];
  assign insert  = (a_data.op == OP_SUBMIT) && !zero && !dup && !too_low;
  assign upd     = advance && insert;

  always_comb begin
    if (upd && !full) begin
      count_next = count + CW'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // valid entries form a prefix, so a valid cell implies slot < count
  always_comb begin
    rd_val = '0;
    rd_vld = 1'b0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (cell_vld[i] && (32'(a_data.slot) == i)) begin
        rd_val = cell_val[i];
        rd_vld = 1'b1;
      end
    end
  end

  assign total_ext = {5'b0, count_next};

  always_comb begin
    rsp_data_next.entry_points = '0;
    rsp_data_next.entry_valid  = 1'b0;
    rsp_data_next.entry_total  = total_ext[4:0];
    if (a_data.op == OP_READ) begin
      rsp_data_next.status       = ST_READ_DONE;
      rsp_data_next.entry_points = (12'(rd_val) << 3) + (12'(rd_val) << 1);
      rsp_data_next.entry_valid  = rd_vld;
    end else if (zero) begin
      rsp_data_next.status = ST_ZERO;
    end else if (dup) begin
      rsp_data_next.status = ST_DUPLICATE;
    end else if (too_low) begin
      rsp_data_next.status = ST_TOO_LOW;
    end else begin
      rsp_data_next.status = ST_INSERTED;
    end
  end

  always_comb begin
    if (advance) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_stall) begin
      rsp_valid_next = rsp_valid;
    end else begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_data <= rsp_data_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_SIZE))
    else $error("entry count beyond table size");

  a_prefix: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_vld) == 32'(count))
    else $error("valid cells disagree with entry count");

  a_grow: assert property (@(posedge clk) disable iff (rst)
    upd && !full |=> count == $past(count) + CW'(1))
    else $error("insert into free slot did not grow the count");

  a_read_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.entry_valid |-> rsp_data.status == ST_READ_DONE)
    else $error("valid entry on a non-read response");

endmodule

@@ rtl/core/tkus_cell.sv @@
// ---------------------------------------------------------------------------
// tkus_cell: one slot of the sorted score row
// Keeps its value, takes the new value or shifts in its left neighbour.
// ---------------------------------------------------------------------------
module tkus_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      upd,
  input  logic [tkus_pkg::VAL_W-1:0] v,
  input  logic                      prev_keep,
  input  logic [tkus_pkg::VAL_W-1:0] prev_val,
  input  logic                      prev_vld,
  output logic [tkus_pkg::VAL_W-1:0] val,
  output logic                      vld,
  output logic                      keep,
  output logic                      match
);
  import tkus_pkg::*;

  logic [VAL_W-1:0] val_next;
  logic             vld_next;

  assign keep  = vld && (val > v);
  assign match = vld && (val == v);

  always_comb begin
    if (keep) begin
      val_next = val;
      vld_next = vld;
    end else if (prev_keep) begin
      val_next = v;
      vld_next = 1'b1;
    end else begin
      val_next = prev_val;
      vld_next = prev_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (upd) begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      val <= val_next;
    end
  end

endmodule

@@ rtl/core/tkus_prep.sv @@
// ---------------------------------------------------------------------------
// tkus_prep: front stage
// Registers the request and scales the score to tenths with saturation.
// ---------------------------------------------------------------------------
module tkus_prep (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic            advance,
  input  tkus_pkg::req_t  req,
  output logic            a_vld,
  output tkus_pkg::prep_t a_data
);
  import tkus_pkg::*;

  logic [32:0] prod;
  logic [13:0] quot;
  prep_t       a_data_next;
  logic        a_vld_next;

  assign prod = 33'(req.score_points) * 33'(DIV_RECIP);
  assign quot = 14'(prod >> DIV_SHIFT);

  always_comb begin
    a_data_next.op   = req.opcode;
    a_data_next.v    = (quot > 14'(MAX_VAL)) ? MAX_VAL : quot[VAL_W-1:0];
    a_data_next.slot = req.read_slot;
  end

  always_comb begin
    if (accept) begin
      a_vld_next = 1'b1;
    end else if (advance) begin
      a_vld_next = 1'b0;
    end else begin
      a_vld_next = a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= a_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_data <= a_data_next;
    end
  end

endmodule
